@@ src/id3v2_text_frame_extractor_defines.svh @@
// ---------------------------------------------------------------------------
// ID3v2 text frame extractor - assertion macros
// Shorthand for clocked implication checks with an active-low reset.
// ---------------------------------------------------------------------------
`ifndef ID3V2_TEXT_FRAME_EXTRACTOR_DEFINES_SVH
`define ID3V2_TEXT_FRAME_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ID3TFE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("id3tfe check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ID3TFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("id3tfe check failed");

`endif

@@ src/id3tfe_pkg.sv @@
// ---------------------------------------------------------------------------
// ID3v2 text frame extractor - package
// Parse phases, result kinds and the table of wanted text frame ids.
// ---------------------------------------------------------------------------
`default_nettype none

package id3tfe_pkg;

    localparam int unsigned WANTED_FRAMES_DEFAULT = 6;
    localparam int unsigned NUM_IDS               = 6;

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_FRAME_HDR = 3'd1,
        PH_PAYLOAD   = 3'd2,
        PH_SKIP      = 3'd3,
        PH_FINISH    = 3'd4,
        PH_IDLE      = 3'd5
    } phase_t;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_PAYLOAD  = 2'd0;
    localparam kind_t KIND_REJECTED = 2'd1;
    localparam kind_t KIND_DONE     = 2'd2;

    // Header bytes
    localparam logic [7:0] MAGIC_I   = 8'h49;
    localparam logic [7:0] MAGIC_D   = 8'h44;
    localparam logic [7:0] MAGIC_3   = 8'h33;
    localparam logic [7:0] VER_MAJ_3 = 8'h03;
    localparam logic [7:0] VER_MAJ_4 = 8'h04;
    localparam logic [7:0] VER_REV   = 8'h00;

    // Frame header layout: id 0..3, size 4..7, flags 8..9, encoding 10
    localparam logic [3:0] HDR_LAST_POS   = 4'd9;
    localparam logic [3:0] FHDR_SIZE_POS  = 4'd4;
    localparam logic [3:0] FHDR_FLAGS_POS = 4'd8;
    localparam logic [3:0] FHDR_ENC_POS   = 4'd10;

    localparam logic [31:0] WANTED_IDS [NUM_IDS] = '{
        32'h54495432,   // TIT2
        32'h54414C42,   // TALB
        32'h54594552,   // TYER
        32'h54434F4E,   // TCON
        32'h54504531,   // TPE1
        32'h434F4D4D    // COMM
    };

    typedef struct packed {
        logic       found;
        logic [2:0] index;
    } id_match_t;

    // First table entry equal to the id wins.
    function automatic id_match_t lookup_id(input logic [31:0] id);
        id_match_t m;
        m.found = 1'b0;
        m.index = 3'd0;
        for (int i = NUM_IDS - 1; i >= 0; i--) begin
            if (id == WANTED_IDS[i]) begin
                m.found = 1'b1;
                m.index = 3'(i);
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ src/id3v2_text_frame_extractor.sv @@
// ---------------------------------------------------------------------------
// ID3v2 text frame extractor
// Walks an ID3v2 tag byte by byte and emits the payload bytes of the wanted
// text frames, a reject result on a bad header and a done result once WANTED_FRAMES of them are found.
// ---------------------------------------------------------------------------
// A result is registered: it is on the output port in the cycle after its byte is taken.
// Throughput: one byte per cycle; in_ready drops only while a result is held
// in the output register and out_ready is low.
// Reset: rst_n clears the parse state to the start of the tag header and
// empties the output register; first_byte restarts the parse likewise.
// ---------------------------------------------------------------------------
`default_nettype none

module id3v2_text_frame_extractor #(
    parameter int unsigned WANTED_FRAMES = id3tfe_pkg::WANTED_FRAMES_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       first_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      kind,
    output logic [2:0]      frame_index,
    output logic [7:0]      payload_byte,
    output logic            last_in_frame
);

    // ---------------------------------------------------------------------
    // Parse state
    // ---------------------------------------------------------------------
    id3tfe_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  pos_reg, pos_next;
    logic [31:0] frame_id_reg, frame_id_next;
    logic [31:0] frame_size_reg, frame_size_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [2:0]  matched_index_reg, matched_index_next;
    logic [2:0]  match_count_reg, match_count_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  kind_reg, kind_next;
    logic [2:0]  frame_index_reg, frame_index_next;
    logic [7:0]  payload_byte_reg, payload_byte_next;
    logic        last_reg, last_next;

    // Working view of the state: a first byte restarts the parse at once
    id3tfe_pkg::phase_t cur_phase;
    logic [3:0]  cur_pos;
    logic [2:0]  cur_count;

    logic        accept;
    logic        header_ok;
    logic        emit;
    logic [31:0] remaining_dec;
    logic [31:0] size_minus_one;
    logic [2:0]  count_inc;
    logic        enough;
    id3tfe_pkg::id_match_t id_hit;

    // The output register frees up when it is empty or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign cur_phase = first_byte ? id3tfe_pkg::PH_HEADER : phase_reg;
    assign cur_pos   = first_byte ? 4'd0 : pos_reg;
    assign cur_count = first_byte ? 3'd0 : match_count_reg;

    assign remaining_dec  = remaining_reg - 32'd1;
    assign size_minus_one = (frame_size_reg != 32'd0) ? frame_size_reg - 32'd1 : 32'd0;
    assign count_inc      = cur_count + 3'd1;
    assign enough         = (cur_count >= 3'(WANTED_FRAMES));
    assign id_hit         = id3tfe_pkg::lookup_id(frame_id_reg);

    // Check one tag header byte against its expected value
    always_comb
    begin
        case (cur_pos)
            4'd0:    header_ok = (data_byte == id3tfe_pkg::MAGIC_I);
            4'd1:    header_ok = (data_byte == id3tfe_pkg::MAGIC_D);
            4'd2:    header_ok = (data_byte == id3tfe_pkg::MAGIC_3);
            4'd3:    header_ok = (data_byte == id3tfe_pkg::VER_MAJ_3)
                              || (data_byte == id3tfe_pkg::VER_MAJ_4);
            4'd4:    header_ok = (data_byte == id3tfe_pkg::VER_REV);
            default: header_ok = 1'b1;
        endcase
    end

    // ---------------------------------------------------------------------
    // Next-state logic
    // ---------------------------------------------------------------------
    always_comb
    begin
        phase_next         = phase_reg;
        pos_next           = pos_reg;
        frame_id_next      = frame_id_reg;
        frame_size_next    = frame_size_reg;
        remaining_next     = remaining_reg;
        matched_index_next = matched_index_reg;
        match_count_next   = match_count_reg;

        if (accept)
        begin
            // Restart on a first byte; the byte itself then parses as header byte 0
            pos_next         = cur_pos;
            match_count_next = cur_count;
            phase_next       = cur_phase;

            unique case (cur_phase)
                id3tfe_pkg::PH_HEADER:
                begin
                    if (!header_ok)
                    begin
                        phase_next = id3tfe_pkg::PH_IDLE;
                    end
                    else if (cur_pos >= id3tfe_pkg::HDR_LAST_POS)
                    begin
                        phase_next = id3tfe_pkg::PH_FRAME_HDR;
                        pos_next   = 4'd0;
                    end
                    else
                    begin
                        pos_next = cur_pos + 4'd1;
                    end
                end

                id3tfe_pkg::PH_FRAME_HDR:
                begin
                    // Shift in id, then size, big-endian
                    if (cur_pos < id3tfe_pkg::FHDR_SIZE_POS)
                        frame_id_next = {frame_id_reg[23:0], data_byte};
                    else if (cur_pos < id3tfe_pkg::FHDR_FLAGS_POS)
                        frame_size_next = {frame_size_reg[23:0], data_byte};

                    if (cur_pos < id3tfe_pkg::FHDR_ENC_POS)
                    begin
                        pos_next = cur_pos + 4'd1;
                    end
                    else
                    begin
                        // Encoding byte closes the frame header
                        pos_next       = 4'd0;
                        remaining_next = size_minus_one;
                        if (id_hit.found)
                        begin
                            matched_index_next = id_hit.index;
                            match_count_next   = count_inc;
                            if (size_minus_one != 32'd0)
                                phase_next = id3tfe_pkg::PH_PAYLOAD;
                            else if (count_inc >= 3'(WANTED_FRAMES))
                                phase_next = id3tfe_pkg::PH_FINISH;
                            else
                                phase_next = id3tfe_pkg::PH_FRAME_HDR;
                        end
                        else
                        begin
                            phase_next = (size_minus_one != 32'd0) ? id3tfe_pkg::PH_SKIP
                                                                   : id3tfe_pkg::PH_FRAME_HDR;
                        end
                    end
                end

                id3tfe_pkg::PH_PAYLOAD:
                begin
                    remaining_next = remaining_dec;
                    if (remaining_dec == 32'd0)
                        phase_next = enough ? id3tfe_pkg::PH_FINISH : id3tfe_pkg::PH_FRAME_HDR;
                end

                id3tfe_pkg::PH_SKIP:
                begin
                    remaining_next = remaining_dec;
                    if (remaining_dec == 32'd0)
                        phase_next = id3tfe_pkg::PH_FRAME_HDR;
                end

                id3tfe_pkg::PH_FINISH:
                begin
                    phase_next = id3tfe_pkg::PH_IDLE;
                end

                id3tfe_pkg::PH_IDLE:
                begin
                    phase_next = id3tfe_pkg::PH_IDLE;
                end

                default:
                begin
                    phase_next = id3tfe_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Result logic: at most one result per accepted byte
    // ---------------------------------------------------------------------
    always_comb
    begin
        emit              = 1'b0;
        kind_next         = id3tfe_pkg::KIND_PAYLOAD;
        frame_index_next  = 3'd0;
        payload_byte_next = 8'd0;
        last_next         = 1'b0;

        unique case (cur_phase)
            id3tfe_pkg::PH_HEADER:
            begin
                if (!header_ok)
                begin
                    emit      = 1'b1;
                    kind_next = id3tfe_pkg::KIND_REJECTED;
                end
            end

            id3tfe_pkg::PH_PAYLOAD:
            begin
                emit              = 1'b1;
                frame_index_next  = matched_index_reg;
                payload_byte_next = data_byte;
                last_next         = (remaining_dec == 32'd0);
            end

            id3tfe_pkg::PH_FINISH:
            begin
                emit      = 1'b1;
                kind_next = id3tfe_pkg::KIND_DONE;
            end

            default:
            begin
                emit = 1'b0;
            end
        endcase

        // Hold the register unless a new transaction loads or drains it
        if (accept)
            out_valid_next = emit;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= id3tfe_pkg::PH_HEADER;
            pos_reg           <= 4'd0;
            match_count_reg   <= 3'd0;
            matched_index_reg <= 3'd0;
            remaining_reg     <= 32'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            pos_reg           <= pos_next;
            match_count_reg   <= match_count_next;
            matched_index_reg <= matched_index_next;
            remaining_reg     <= remaining_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Id and size are fully shifted in before use: no reset needed
    always_ff @(posedge clk)
    begin
        frame_id_reg   <= frame_id_next;
        frame_size_reg <= frame_size_next;
        if (accept && emit)
        begin
            kind_reg         <= kind_next;
            frame_index_reg  <= frame_index_next;
            payload_byte_reg <= payload_byte_next;
            last_reg         <= last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign frame_index   = frame_index_reg;
    assign payload_byte  = payload_byte_reg;
    assign last_in_frame = last_reg;

endmodule

`default_nettype wire

@@ src/id3v2_text_frame_extractor_checker.sv @@
// ---------------------------------------------------------------------------
// ID3v2 text frame extractor - port checker
// Watches the top-level ports and flags illegal result encodings and stalls.
// ---------------------------------------------------------------------------
`default_nettype none

`include "id3v2_text_frame_extractor_defines.svh"

module id3v2_text_frame_extractor_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] kind,
    input wire logic [2:0] frame_index,
    input wire logic [7:0] payload_byte,
    input wire logic       last_in_frame
);

    logic        stalled;
    logic [13:0] result_bits;
    logic        kind_legal;
    logic        is_status;
    logic        is_payload;
    logic        status_clean;

    assign stalled      = out_valid && !out_ready;
    assign result_bits  = {kind, frame_index, payload_byte, last_in_frame};
    assign kind_legal   = (kind == id3tfe_pkg::KIND_PAYLOAD)
                       || (kind == id3tfe_pkg::KIND_REJECTED)
                       || (kind == id3tfe_pkg::KIND_DONE);
    assign is_status    = out_valid && (kind != id3tfe_pkg::KIND_PAYLOAD);
    assign is_payload   = out_valid && (kind == id3tfe_pkg::KIND_PAYLOAD);
    assign status_clean = (frame_index == 3'd0) && (payload_byte == 8'd0) && !last_in_frame;

    // Hold a stalled result unchanged
    `ID3TFE_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, out_valid && $stable(result_bits))

    // A full, stalled output register blocks new bytes
    `ID3TFE_ASSERT_IMPLY(a_full_blocks, clk, rst_n, stalled, !in_ready)

    // Only the three defined kinds appear
    `ID3TFE_ASSERT_IMPLY(a_kind_legal, clk, rst_n, out_valid, kind_legal)

    // Status results carry zeroed payload fields
    `ID3TFE_ASSERT_IMPLY(a_status_clean, clk, rst_n, is_status, status_clean)

    // Payload bytes name one of the six wanted frames
    `ID3TFE_ASSERT_IMPLY(a_index_range, clk, rst_n, is_payload, frame_index <= 3'd5)

endmodule

bind id3v2_text_frame_extractor id3v2_text_frame_extractor_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .frame_index   (frame_index),
    .payload_byte  (payload_byte),
    .last_in_frame (last_in_frame)
);

`default_nettype wire
